@@ hdl/amru_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// amru_pkg
// Shared types, codes and helper functions of the atomic memory RMW unit.
// -----------------------------------------------------------------------------
package amru_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int BANKS           = 8;
	localparam int POS_W           = 17;
	localparam int END_W           = 22;

	localparam logic [3:0] CMD_LOAD    = 4'd0;
	localparam logic [3:0] CMD_STORE   = 4'd1;
	localparam logic [3:0] CMD_ADD     = 4'd2;
	localparam logic [3:0] CMD_SUB     = 4'd3;
	localparam logic [3:0] CMD_AND     = 4'd4;
	localparam logic [3:0] CMD_OR      = 4'd5;
	localparam logic [3:0] CMD_XOR     = 4'd6;
	localparam logic [3:0] CMD_XCHG    = 4'd7;
	localparam logic [3:0] CMD_CMPXCHG = 4'd8;
	localparam logic [3:0] CMD_LAST    = CMD_CMPXCHG;

	localparam logic [3:0] TYPE_LAST   = 4'd7;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_TYPE_ERR  = 2'd1;
	localparam logic [1:0] STS_RANGE_ERR = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} amru_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic finish;
	} amru_cmd_t;

	typedef struct packed {
		logic clear_last;
	} amru_sts_t;

	function automatic logic [63:0] amru_width_mask(input logic [1:0] szl);
		logic [63:0] m;
		unique case (szl)
			2'd0: m = 64'h0000_0000_0000_00FF;
			2'd1: m = 64'h0000_0000_0000_FFFF;
			2'd2: m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] amru_extend(input logic [63:0] raw,
		input logic [1:0] szl, input logic sgn);
		logic [63:0] v;
		unique case (szl)
			2'd0: v = {{56{sgn & raw[7]}}, raw[7:0]};
			2'd1: v = {{48{sgn & raw[15]}}, raw[15:0]};
			2'd2: v = {{32{sgn & raw[31]}}, raw[31:0]};
			default: v = raw;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/atomic_memory_rmw_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// atomic_memory_rmw_unit
// Atomic load/store/read-modify-write unit over a little-endian byte store.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall) carries command, elem_type,
//   view_offset, view_length, element_index, operand and expected.
//   Result channel (out_valid/out_stall) carries result_value and status,
//   one result per request, in request order.
//   A request is registered with its bank read when accepted; the modify and
//   write-back step then loads the result register once that register is
//   free. The unit takes no new request until that step is done.
//   A new request is accepted while the previous result still waits.
//   Reset: the store is cleared to zero by a pass over all rows, one row of
//   eight bytes per cycle; in_stall stays high during the pass.
//   When out_stall is high the result holds, and a pending request waits in
//   its modify step without writing the store until the result is taken.
// -----------------------------------------------------------------------------
module atomic_memory_rmw_unit #(
	parameter int STORE_BYTES = amru_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [3:0]  elem_type,
	input  logic [11:0] view_offset,
	input  logic [12:0] view_length,
	input  logic [31:0] element_index,
	input  logic [63:0] operand,
	input  logic [63:0] expected,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_value,
	output logic [1:0]  status
);
	import amru_pkg::*;

	amru_cmd_t cmd;
	amru_sts_t sts;

	amru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	amru_dpath #(
		.STORE_BYTES(STORE_BYTES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.elem_type    (elem_type),
		.view_offset  (view_offset),
		.view_length  (view_length),
		.element_index(element_index),
		.operand      (operand),
		.expected     (expected),
		.result_value (result_value),
		.status       (status)
	);

endmodule

@@ hdl/amru_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// amru_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while read enable is low.
// -----------------------------------------------------------------------------
module amru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/amru_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// amru_ctrl
// Controller: clearing pass after reset, request acceptance, and the
// modify/write-back step gated by the output register.
// -----------------------------------------------------------------------------
module amru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  amru_pkg::amru_sts_t sts,
	output amru_pkg::amru_cmd_t cmd
);
	import amru_pkg::*;

	amru_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q & out_stall;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/amru_dpath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// amru_dpath
// Datapath: request checks and address generation, eight byte-wide RAM
// banks (byte address modulo 8 selects the bank), modify logic and the
// result register.
// -----------------------------------------------------------------------------
module amru_dpath #(
	parameter int STORE_BYTES = amru_pkg::STORE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  amru_pkg::amru_cmd_t cmd,
	output amru_pkg::amru_sts_t sts,
	input  logic [3:0]          command,
	input  logic [3:0]          elem_type,
	input  logic [11:0]         view_offset,
	input  logic [12:0]         view_length,
	input  logic [31:0]         element_index,
	input  logic [63:0]         operand,
	input  logic [63:0]         expected,
	output logic [63:0]         result_value,
	output logic [1:0]          status
);
	import amru_pkg::*;

	localparam int ROWS = (STORE_BYTES + BANKS - 1) / BANKS;
	localparam int AW   = $clog2(ROWS);

	// request checks and bank addresses
	logic              type_bad, range_bad;
	logic [1:0]        szl;
	logic [POS_W-1:0]  pos;
	logic [END_W-1:0]  pos_end;
	logic [POS_W-4:0]  row0, row1;
	logic [1:0]        sts_in;
	logic [AW-1:0]     raddr [BANKS];

	assign szl       = elem_type[2:1];
	assign type_bad  = (elem_type > TYPE_LAST) || (command > CMD_LAST);
	assign pos       = POS_W'(view_offset) + (POS_W'(element_index[12:0]) << szl);
	assign pos_end   = END_W'(pos) + (END_W'(1) << szl);
	assign range_bad = (element_index >= 32'(view_length)) ||
		(pos_end > END_W'(STORE_BYTES));
	assign sts_in    = type_bad ? STS_TYPE_ERR : (range_bad ? STS_RANGE_ERR : STS_OK);
	assign row0      = pos[POS_W-1:3];
	assign row1      = row0 + 1'b1;

	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			raddr[b] = (3'(b) >= pos[2:0]) ? AW'(row0) : AW'(row1);
		end
	end

	// request register
	logic [3:0]  cmd_s1;
	logic [1:0]  szl_s1;
	logic        sgn_s1;
	logic [2:0]  lane_s1;
	logic [1:0]  status_s1;
	logic [63:0] operand_s1, expected_s1;
	logic [AW-1:0] addr_s1 [BANKS];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_s1      <= command;
			szl_s1      <= szl;
			sgn_s1      <= ~elem_type[0];
			lane_s1     <= pos[2:0];
			status_s1   <= sts_in;
			operand_s1  <= operand;
			expected_s1 <= expected;
			addr_s1     <= raddr;
		end
	end

	// clearing pass
	logic [AW-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (cmd.clear) begin
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_row_q == AW'(ROWS - 1));

	// banks
	logic [7:0]    rdata [BANKS];
	logic [7:0]    wdata [BANKS];
	logic [AW-1:0] waddr [BANKS];
	logic          we    [BANKS];

	for (genvar g = 0; g < BANKS; g++) begin : g_bank
		amru_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we[g]),
			.waddr(waddr[g]),
			.wdata(wdata[g]),
			.re   (cmd.accept),
			.raddr(raddr[g]),
			.rdata(rdata[g])
		);
	end

	// modify
	logic [63:0] raw_full, mask, raw, nv, nv_m;
	logic        wr_en;
	logic [2:0]  k;
	logic        touched;

	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			raw_full[8*i +: 8] = rdata[lane_s1 + 3'(i)];
		end
	end

	assign mask = amru_width_mask(szl_s1);
	assign raw  = raw_full & mask;

	always_comb begin
		nv = raw;
		unique case (cmd_s1) inside
			CMD_STORE, CMD_XCHG: nv = operand_s1;
			CMD_ADD:             nv = raw + operand_s1;
			CMD_SUB:             nv = raw - operand_s1;
			CMD_AND:             nv = raw & operand_s1;
			CMD_OR:              nv = raw | operand_s1;
			CMD_XOR:             nv = raw ^ operand_s1;
			CMD_CMPXCHG:         nv = ((expected_s1 & mask) == raw) ? operand_s1 : raw;
			default:             nv = raw;
		endcase
	end

	assign nv_m  = nv & mask;
	assign wr_en = cmd.finish && (status_s1 == STS_OK) && (cmd_s1 != CMD_LOAD);

	always_comb begin
		k       = '0;
		touched = 1'b0;
		for (int b = 0; b < BANKS; b++) begin
			k        = 3'(b) - lane_s1;
			touched  = ({1'b0, k} < (4'd1 << szl_s1));
			we[b]    = cmd.clear || (wr_en && touched);
			waddr[b] = cmd.clear ? clr_row_q : addr_s1[b];
			wdata[b] = cmd.clear ? 8'd0 : nv_m[{k, 3'b000} +: 8];
		end
	end

	// result register
	logic [63:0] result_value_q;
	logic [1:0]  status_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= status_s1;
			if (status_s1 != STS_OK) begin
				result_value_q <= '0;
			end else if (cmd_s1 == CMD_STORE) begin
				result_value_q <= operand_s1;
			end else begin
				result_value_q <= amru_extend(raw, szl_s1, sgn_s1);
			end
		end
	end

	assign result_value = result_value_q;
	assign status       = status_q;

endmodule

@@ hdl/amru_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// amru_checker
// Port-level checks of the atomic memory RMW unit, bound to the top level.
// -----------------------------------------------------------------------------
module amru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [3:0]  command,
	input logic [3:0]  elem_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_value,
	input logic [1:0]  status
);
	import amru_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("request accepted while previous one in flight");

	// result follows once the output register is free
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("result not delivered on time");

	// rejected type or unknown command reports a type error with zero value
	a_type_err: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ((elem_type > TYPE_LAST) || (command > CMD_LAST)))
		##1 (!out_valid || !out_stall)
		|=> (out_valid && (status == STS_TYPE_ERR) && (result_value == 64'd0)))
		else $error("rejected type not reported");

	// hold stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(result_value) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind atomic_memory_rmw_unit amru_checker u_amru_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for atomic_memory_rmw_unit: drives typed atomic requests
// under random idling and back-pressure, mirrors the byte store to predict each
// returned value and status, and compares every result in order.
// -----------------------------------------------------------------------------
module tb;

	import amru_pkg::*;

	localparam int STORE_BYTES = STORE_BYTES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [3:0] TYPE_I8      = 4'd0;
	localparam logic [3:0] TYPE_U8      = 4'd1;
	localparam logic [3:0] TYPE_I16     = 4'd2;
	localparam logic [3:0] TYPE_U16     = 4'd3;
	localparam logic [3:0] TYPE_I32     = 4'd4;
	localparam logic [3:0] TYPE_U32     = 4'd5;
	localparam logic [3:0] TYPE_I64     = 4'd6;
	localparam logic [3:0] TYPE_U64     = 4'd7;
	localparam logic [3:0] TYPE_CLAMPED = 4'd8;
	localparam logic [3:0] TYPE_F64     = 4'd10;

	typedef struct {
		logic [3:0]  cmd;
		logic [3:0]  etype;
		logic [11:0] voff;
		logic [12:0] vlen;
		logic [31:0] idx;
		logic [63:0] opnd;
		logic [63:0] cmpv;
	} amo_req_t;

	typedef struct {
		logic [63:0] value;
		logic [1:0]  sts;
	} amo_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  command;
	logic [3:0]  elem_type;
	logic [11:0] view_offset;
	logic [12:0] view_length;
	logic [31:0] element_index;
	logic [63:0] operand;
	logic [63:0] expected;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_value;
	logic [1:0]  status;

	logic [7:0] mem_mirror [STORE_BYTES];
	amo_res_t   pending_results [$];
	int         mismatch_count;
	int         cycle_count;
	int         tx_idle_pct;
	int         rx_idle_pct;
	logic       hold_req;
	int         hold_left;

	atomic_memory_rmw_unit #(
		.STORE_BYTES(STORE_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.elem_type(elem_type),
		.view_offset(view_offset),
		.view_length(view_length),
		.element_index(element_index),
		.operand(operand),
		.expected(expected),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] lane_mask(input int unsigned nbytes);
		if (nbytes >= 8)
			return '1;
		return (64'd1 << (8 * nbytes)) - 64'd1;
	endfunction

	function automatic logic [63:0] stored_bits(input longint unsigned pos,
		input int unsigned nbytes);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < nbytes; i++)
			v[8 * i +: 8] = mem_mirror[pos + i];
		return v;
	endfunction

	function automatic amo_res_t apply_atomic(input amo_req_t r);
		amo_res_t res;
		int unsigned nbytes;
		longint unsigned pos;
		logic [63:0] bmask;
		logic [63:0] old_bits;
		logic [63:0] new_bits;
		res.value = '0;
		res.sts = STS_OK;
		if (r.etype > TYPE_U64 || r.cmd > CMD_CMPXCHG) begin
			res.sts = STS_TYPE_ERR;
			return res;
		end
		nbytes = 1 << r.etype[2:1];
		pos = 64'(r.voff) + 64'(r.idx) * 64'(nbytes);
		if (32'(r.idx) >= 32'(r.vlen) || pos + nbytes > STORE_BYTES) begin
			res.sts = STS_RANGE_ERR;
			return res;
		end
		bmask = lane_mask(nbytes);
		old_bits = stored_bits(pos, nbytes);
		case (r.cmd)
			CMD_LOAD:    new_bits = old_bits;
			CMD_STORE:   new_bits = r.opnd;
			CMD_ADD:     new_bits = old_bits + r.opnd;
			CMD_SUB:     new_bits = old_bits - r.opnd;
			CMD_AND:     new_bits = old_bits & r.opnd;
			CMD_OR:      new_bits = old_bits | r.opnd;
			CMD_XOR:     new_bits = old_bits ^ r.opnd;
			CMD_XCHG:    new_bits = r.opnd;
			default:     new_bits = ((r.cmpv & bmask) == old_bits) ? r.opnd : old_bits;
		endcase
		if (r.cmd != CMD_LOAD)
			for (int i = 0; i < nbytes; i++)
				mem_mirror[pos + i] = new_bits[8 * i +: 8];
		if (r.cmd == CMD_STORE) begin
			res.value = r.opnd;
		end else begin
			res.value = old_bits;
			if (!r.etype[0] && nbytes < 8 && old_bits[8 * nbytes - 1])
				res.value = old_bits | ~bmask;
		end
		return res;
	endfunction

	function automatic amo_req_t mk_req(input logic [3:0] cmd, input logic [3:0] etype,
		input logic [11:0] voff, input logic [12:0] vlen, input logic [31:0] idx,
		input logic [63:0] opnd, input logic [63:0] cmpv);
		amo_req_t r;
		r.cmd = cmd;
		r.etype = etype;
		r.voff = voff;
		r.vlen = vlen;
		r.idx = idx;
		r.opnd = opnd;
		r.cmpv = cmpv;
		return r;
	endfunction

	function automatic amo_req_t make_random_req();
		amo_req_t r;
		int sel;
		int unsigned nbytes;
		longint unsigned pos;
		logic [63:0] bmask;
		sel = $urandom_range(99);
		r.opnd = {$urandom(), $urandom()};
		r.cmpv = {$urandom(), $urandom()};
		if ($urandom_range(3) == 0)
			r.opnd = 64'($urandom_range(3));
		if (sel >= 85) begin
			r.cmd = 4'($urandom_range(15));
			r.etype = 4'($urandom_range(15));
			r.voff = 12'($urandom_range(4095));
			r.vlen = 13'($urandom_range(4096));
			r.idx = $urandom_range(1) ? $urandom() : $urandom_range(63);
			return r;
		end
		r.cmd = 4'($urandom_range(CMD_CMPXCHG));
		r.etype = 4'($urandom_range(TYPE_U64));
		if (sel < 65) begin
			r.voff = 12'($urandom_range(63));
			r.vlen = 13'($urandom_range(1, 16));
			r.idx = $urandom_range(r.vlen - 1);
		end else if (sel < 72) begin
			r.voff = 12'($urandom_range(4095));
			r.vlen = 13'($urandom_range(1, 4096));
			r.idx = $urandom_range(r.vlen - 1);
		end else if (sel < 79) begin
			r.voff = 12'($urandom_range(4032, 4095));
			r.vlen = 13'($urandom_range(1, 16));
			r.idx = $urandom_range(r.vlen - 1);
		end else begin
			r.voff = 12'($urandom_range(4095));
			r.vlen = 13'($urandom_range(4096));
			r.idx = $urandom_range(1) ? 32'(r.vlen) : $urandom();
			if (32'(r.idx) < 32'(r.vlen))
				r.idx = 32'(r.vlen);
		end
		nbytes = 1 << r.etype[2:1];
		pos = 64'(r.voff) + 64'(r.idx) * 64'(nbytes);
		if (r.cmd == CMD_CMPXCHG && $urandom_range(1) && 32'(r.idx) < 32'(r.vlen)
			&& pos + nbytes <= STORE_BYTES) begin
			bmask = lane_mask(nbytes);
			r.cmpv = (r.cmpv & ~bmask) | stored_bits(pos, nbytes);
		end
		return r;
	endfunction

	task automatic send_req(input amo_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= r.cmd;
		elem_type <= r.etype;
		view_offset <= r.voff;
		view_length <= r.vlen;
		element_index <= r.idx;
		operand <= r.opnd;
		expected <= r.cmpv;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
		pending_results.push_back(apply_atomic(r));
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		tx_idle_pct = 7;
		rx_idle_pct <= 45;
		send_req(mk_req(CMD_STORE, TYPE_U64, 12'd0, 13'd1, 32'd0,
			64'hF0E1_D2C3_8475_A6B7, 64'd0));
		for (int t = TYPE_I8; t <= TYPE_U64; t++)
			send_req(mk_req(CMD_LOAD, 4'(t), 12'd0, 13'd1, 32'd0, 64'd0, 64'd0));
		send_req(mk_req(CMD_ADD, TYPE_U8, 12'd0, 13'd1, 32'd0, 64'hFFFF_FFFF_FFFF_FF49, 64'd0));
		send_req(mk_req(CMD_SUB, TYPE_I16, 12'd0, 13'd4, 32'd1, 64'h8476, 64'd0));
		send_req(mk_req(CMD_AND, TYPE_U32, 12'd4, 13'd1, 32'd0, 64'h0F0F_0F0F, 64'd0));
		send_req(mk_req(CMD_OR, TYPE_I64, 12'd8, 13'd2, 32'd1, '1, 64'd0));
		send_req(mk_req(CMD_XOR, TYPE_U64, 12'd8, 13'd2, 32'd1, {4{16'h5555}}, 64'd0));
		send_req(mk_req(CMD_XCHG, TYPE_I8, 12'd4095, 13'd1, 32'd0, 64'h80, 64'd0));
		send_req(mk_req(CMD_CMPXCHG, TYPE_I8, 12'd4095, 13'd1, 32'd0, 64'h7F,
			64'hFFFF_FF80));
		send_req(mk_req(CMD_CMPXCHG, TYPE_I8, 12'd4095, 13'd1, 32'd0, 64'h11, 64'h80));
		send_req(mk_req(CMD_LOAD, TYPE_I16, 12'd4095, 13'd1, 32'd0, 64'd0, 64'd0));
		send_req(mk_req(CMD_LOAD, TYPE_U64, 12'd4088, 13'd4096, 32'd0, 64'd0, 64'd0));
		send_req(mk_req(CMD_LOAD, TYPE_U8, 12'd0, 13'd4096, 32'd4096, 64'd0, 64'd0));
		send_req(mk_req(CMD_STORE, TYPE_U8, 12'd0, 13'd0, 32'd0, 64'h1234, 64'd0));
		send_req(mk_req(CMD_LOAD, TYPE_U8, 12'd0, 13'd4096, 32'hFFFF_FFFF, 64'd0, 64'd0));
		send_req(mk_req(CMD_LOAD, TYPE_CLAMPED, 12'd0, 13'd1, 32'd5, 64'd0, 64'd0));
		send_req(mk_req(CMD_STORE, TYPE_F64, 12'd0, 13'd1, 32'd0, '1, 64'd0));
		send_req(mk_req(4'd15, TYPE_I8, 12'd0, 13'd1, 32'd0, '1, '1));
		wait_results_done();
	endtask

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		repeat (count)
			send_req(make_random_req());
		wait_results_done();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_req <= 1'b1;
		repeat (40)
			send_req(make_random_req());
		wait_results_done();
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_req <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		amo_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: value %h status %0d", result_value, status);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value || status !== want.sts) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected value %h status %0d, got value %h status %0d",
							want.value, want.sts, result_value, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("atomic_memory_rmw_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = CMD_LOAD;
		elem_type = TYPE_I8;
		view_offset = '0;
		view_length = '0;
		element_index = '0;
		operand = '0;
		expected = '0;
		hold_req = 1'b0;
		hold_left = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		mismatch_count = 0;
		cycle_count = 0;
		for (int i = 0; i < STORE_BYTES; i++)
			mem_mirror[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(420, 7, 45);
		test_random(420, 45, 7);
		test_backpressure();
		test_random(400, 0, 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("atomic_memory_rmw_unit test passed");
		else
			$display("atomic_memory_rmw_unit test failed");
		$finish;
	end

endmodule
